[rtl/bresenham_line_rasterizer_defines.svh]
// Assertion macros used by the checker file of the line rasterizer.
`ifndef BRESENHAM_LINE_RASTERIZER_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// The consequent must hold in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

[rtl/blr_pkg.sv]
// Shared widths, types and command codes of the line rasterizer.
package blr_pkg;

    localparam int COORD_BITS     = 11;
    localparam int SPAN_BITS      = COORD_BITS + 1;
    localparam int INC_SMALL_BITS = COORD_BITS + 2;
    localparam int ERR_BITS       = COORD_BITS + 3;
    localparam int IN_DATA_BITS   = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS  = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [SPAN_BITS-1:0]         t_span;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

endpackage

[rtl/bresenham_line_rasterizer.sv]
// Bresenham line rasterizer for all octants with a stream interface.
// A step that finds a line in progress registers its pixel in the output buffer.
// One command per cycle while o_s_tready is high; loads and steps go back to back.
// A two-entry output buffer keeps input ready registered while output stalls.
// Synchronous active-low reset clears the line state and empties the buffer.
module bresenham_line_rasterizer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // x_start, y_start, x_end, y_end, zero fill
    input  logic [blr_pkg::IN_DATA_BITS-1:0]  i_s_tdata,
    // command
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // pixel_x, pixel_y, zero fill
    output logic [blr_pkg::OUT_DATA_BITS-1:0] o_m_tdata,
    output logic                              o_m_tlast
);
    import blr_pkg::*;

    t_coord                    r_cur_x, r_cur_y, r_major_end;
    logic signed [ERR_BITS-1:0] r_err, r_inc_big;
    logic [INC_SMALL_BITS-1:0] r_inc_small;
    logic                      r_x_major, r_minor_neg, r_busy;

    t_coord                    n_cur_x, n_cur_y, n_major_end;
    logic signed [ERR_BITS-1:0] n_err, n_inc_big;
    logic [INC_SMALL_BITS-1:0] n_inc_small;
    logic                      n_x_major, n_minor_neg, n_busy;

    logic                      r_out_valid, r_skid_valid;
    t_coord                    r_out_x, r_out_y, r_skid_x, r_skid_y;
    logic                      r_out_last, r_skid_last;

    t_coord                    xs, ys, xe, ye, sx, sy, ex, ey;
    logic signed [SPAN_BITS-1:0] diff_x, diff_y;
    t_span                     dx, dy, dmaj, dmin;
    logic                      ld_x_major, ld_swap;
    logic                      accept, is_load, is_step, push, pop, last;
    t_coord                    minor_delta;

    assign xs = t_coord'(i_s_tdata[COORD_BITS-1:0]);
    assign ys = t_coord'(i_s_tdata[2*COORD_BITS-1:COORD_BITS]);
    assign xe = t_coord'(i_s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
    assign ye = t_coord'(i_s_tdata[4*COORD_BITS-1:3*COORD_BITS]);

    assign diff_x = {xs[COORD_BITS-1], xs} - {xe[COORD_BITS-1], xe};
    assign diff_y = {ys[COORD_BITS-1], ys} - {ye[COORD_BITS-1], ye};
    assign dx = diff_x[SPAN_BITS-1] ? t_span'(-diff_x) : t_span'(diff_x);
    assign dy = diff_y[SPAN_BITS-1] ? t_span'(-diff_y) : t_span'(diff_y);
    assign ld_x_major = dx > dy;
    assign ld_swap = ld_x_major ? (xs > xe) : (ys > ye);
    assign sx = ld_swap ? xe : xs;
    assign sy = ld_swap ? ye : ys;
    assign ex = ld_swap ? xs : xe;
    assign ey = ld_swap ? ys : ye;
    assign dmaj = ld_x_major ? dx : dy;
    assign dmin = ld_x_major ? dy : dx;

    assign o_s_tready = !r_skid_valid;
    assign accept  = i_s_tvalid && o_s_tready;
    assign is_load = accept && (i_s_tuser == CMD_LOAD);
    assign is_step = accept && (i_s_tuser == CMD_STEP);
    assign push    = is_step && r_busy;
    assign pop     = r_out_valid && i_m_tready;
    assign last    = (r_x_major ? r_cur_x : r_cur_y) == r_major_end;
    assign minor_delta = r_minor_neg ? t_coord'(-1) : t_coord'(1);

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_major_end = r_major_end;
        n_err       = r_err;
        n_inc_big   = r_inc_big;
        n_inc_small = r_inc_small;
        n_x_major   = r_x_major;
        n_minor_neg = r_minor_neg;
        n_busy      = r_busy;
        if (is_load) begin
            n_cur_x     = sx;
            n_cur_y     = sy;
            n_major_end = ld_x_major ? ex : ey;
            n_minor_neg = ld_x_major ? (ey < sy) : (ex < sx);
            n_x_major   = ld_x_major;
            n_inc_small = {dmin, 1'b0};
            n_err       = {1'b0, dmin, 1'b0} - {2'b00, dmaj};
            n_inc_big   = {1'b0, dmin, 1'b0} - {1'b0, dmaj, 1'b0};
            n_busy      = 1'b1;
        end else if (push) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                if (r_err[ERR_BITS-1]) begin
                    n_err = r_err + {1'b0, r_inc_small};
                    if (r_x_major) begin
                        n_cur_x = r_cur_x + t_coord'(1);
                    end else begin
                        n_cur_y = r_cur_y + t_coord'(1);
                    end
                end else begin
                    n_err = r_err + r_inc_big;
                    if (r_x_major) begin
                        n_cur_x = r_cur_x + t_coord'(1);
                        n_cur_y = r_cur_y + minor_delta;
                    end else begin
                        n_cur_y = r_cur_y + t_coord'(1);
                        n_cur_x = r_cur_x + minor_delta;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_major_end <= '0;
            r_err       <= '0;
            r_inc_big   <= '0;
            r_inc_small <= '0;
            r_x_major   <= 1'b0;
            r_minor_neg <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_major_end <= n_major_end;
            r_err       <= n_err;
            r_inc_big   <= n_inc_big;
            r_inc_small <= n_inc_small;
            r_x_major   <= n_x_major;
            r_minor_neg <= n_minor_neg;
            r_busy      <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (pop) begin
            if (r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (!r_out_valid) begin
            r_out_valid <= push;
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && r_skid_valid) begin
            r_out_x    <= r_skid_x;
            r_out_y    <= r_skid_y;
            r_out_last <= r_skid_last;
        end else if (pop || !r_out_valid) begin
            r_out_x    <= r_cur_x;
            r_out_y    <= r_cur_y;
            r_out_last <= last;
        end
        if (!pop && r_out_valid && push) begin
            r_skid_x    <= r_cur_x;
            r_skid_y    <= r_cur_y;
            r_skid_last <= last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_BITS'({r_out_y, r_out_x});
    assign o_m_tlast  = r_out_last;

endmodule

[rtl/blr_checker.sv]
// Port-level checker for the line rasterizer and its bind statement.
`include "bresenham_line_rasterizer_defines.svh"

module blr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [blr_pkg::IN_DATA_BITS-1:0]  i_s_tdata,
    input logic                              i_s_tuser,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [blr_pkg::OUT_DATA_BITS-1:0] o_m_tdata,
    input logic                              o_m_tlast
);
    import blr_pkg::*;

    logic load_xfer;
    logic in_wait;

    assign load_xfer = i_s_tvalid && o_s_tready && (i_s_tuser == CMD_LOAD);
    assign in_wait   = i_s_tvalid && !o_s_tready;

    // A stalled output transfer keeps its pixel.
    `BLR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
    // A waiting input transfer keeps its command and data.
    `BLR_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_s_tvalid && $stable({i_s_tuser, i_s_tdata}))
    // A load never produces a pixel.
    `BLR_ASSERT_NEXT(a_load_empty, i_clk, i_rst_n, load_xfer && !o_m_tvalid, !o_m_tvalid)
    // Input backpressure only appears while the output holds a pixel.
    `BLR_ASSERT_SAME(a_stall_full, i_clk, i_rst_n, !o_s_tready, o_m_tvalid)
    // A full buffer stays full while the output is stalled.
    `BLR_ASSERT_NEXT(a_stall_keeps, i_clk, i_rst_n, !o_s_tready && !i_m_tready, !o_s_tready)

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
